// ===== sv/oate_pkg.sv =====
// shared types and constants of the ordered array table engine
package oate_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned DATA_W = 32;

  // priority encoder split: groups of eight flags
  localparam int unsigned GRP_W  = 3;
  localparam int unsigned GRP    = 8;
  localparam int unsigned NGRP   = DEPTH / GRP;
  localparam int unsigned NGRP_W = IDX_W - GRP_W;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_SEARCH = 3'd4,
    OP_READ   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_BADPOS    = 3'd3,
    STAT_NOTFOUND  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_DELETE = 2'd3
  } cell_cmd_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_SEARCH = 1'b1
  } state_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_cmd_e          cmd;
    logic [IDX_W-1:0]   pos;
    logic [CNT_W-1:0]   count;
    logic               search_en;
  } cell_ctrl_t;

endpackage

// ===== sv/ordered_array_table_engine.sv =====
// top level: chain of table cells, status decode and result register
// Clear, append, insert, delete and read complete at the transfer edge: the cell chain
// shifts or loads at that edge and the result is registered at that same edge. A search
// is split: every cell registers its own compare flag at the transfer edge, and the next
// cycle a two-level priority encoder picks the lowest matching position. A new item is
// taken whenever no search is in flight and the result register is empty or being drained
// in that cycle: one item per cycle unless the output stalls, and a search delays the next.
module ordered_array_table_engine
  import oate_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        operation_i,
  input  logic [IDX_W-1:0]  position_i,
  input  logic [DATA_W-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [IDX_W-1:0]  found_position_o,
  output logic [DATA_W-1:0] read_value_o,
  output logic [CNT_W-1:0]  entry_count_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [IDX_W-1:0]  out_found_q, out_found_d;
  logic [DATA_W-1:0] out_read_q, out_read_d;
  logic [CNT_W-1:0]  out_count_q, out_count_d;

  logic              in_accept;
  logic              out_free;
  logic              load;
  op_e               op;
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] entry [DEPTH];
  logic [DEPTH-1:0]  match;
  logic              hit;
  logic [IDX_W-1:0]  hit_pos;
  logic [DATA_W-1:0] rd_mux;
  logic [CNT_W-1:0]  pos_ext;

  assign op        = op_e'(operation_i);
  assign pos_ext   = {1'b0, position_i};
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_accept = in_valid_i && !in_stall_o;

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] lower, upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = entry[i+1];
    end
    oate_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .ctrl_i  (ctrl),
      .value_i (value_i),
      .lower_i (lower),
      .upper_i (upper),
      .entry_o (entry[i]),
      .match_o (match[i])
    );
  end

  oate_prio u_prio (
    .match_i (match),
    .hit_o   (hit),
    .pos_o   (hit_pos)
  );

  // one-hot read select across the chain
  always_comb begin
    rd_mux = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_mux = rd_mux | ((position_i == IDX_W'(i)) ? entry[i] : '0);
    end
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    load          = 1'b0;
    ctrl.cmd      = CMD_HOLD;
    ctrl.pos      = position_i;
    ctrl.count    = count_q;
    ctrl.search_en = 1'b0;
    out_status_d  = STAT_OK;
    out_found_d   = '0;
    out_read_d    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          load = 1'b1;
          case (op)
            OP_CLEAR: count_d = '0;
            OP_APPEND: begin
              if (count_q == FULL_COUNT) begin
                out_status_d = STAT_FULL;
              end else begin
                ctrl.cmd = CMD_APPEND;
                count_d  = count_q + CNT_W'(1);
              end
            end
            OP_INSERT: begin
              if (count_q == FULL_COUNT) begin
                out_status_d = STAT_FULL;
              end else if (pos_ext > count_q) begin
                out_status_d = STAT_BADPOS;
              end else begin
                ctrl.cmd = CMD_INSERT;
                count_d  = count_q + CNT_W'(1);
              end
            end
            OP_DELETE: begin
              if (count_q == '0) begin
                out_status_d = STAT_EMPTY;
              end else if (pos_ext >= count_q) begin
                out_status_d = STAT_BADPOS;
              end else begin
                ctrl.cmd = CMD_DELETE;
                count_d  = count_q - CNT_W'(1);
              end
            end
            OP_SEARCH: begin
              load           = 1'b0;
              ctrl.search_en = 1'b1;
              state_d        = ST_SEARCH;
            end
            OP_READ: begin
              if (count_q == '0) begin
                out_status_d = STAT_EMPTY;
              end else if (pos_ext >= count_q) begin
                out_status_d = STAT_BADPOS;
              end else begin
                out_read_d = rd_mux;
              end
            end
            default: out_status_d = STAT_OK;
          endcase
        end
      end
      ST_SEARCH: begin
        if (out_free) begin
          load         = 1'b1;
          out_status_d = hit ? STAT_OK : STAT_NOTFOUND;
          out_found_d  = hit ? hit_pos : '0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_count_d = count_d;
    out_valid_d = load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_status_q <= out_status_d;
      out_found_q  <= out_found_d;
      out_read_q   <= out_read_d;
      out_count_q  <= out_count_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign found_position_o = out_found_q;
  assign read_value_o     = out_read_q;
  assign entry_count_o    = out_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_COUNT)
    else $error("entry count beyond table depth");

  a_search_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (op == OP_SEARCH) |=> (state_q == ST_SEARCH) && !out_valid_q || out_stall_i
      || (state_q == ST_SEARCH))
    else $error("search transfer did not enter the search step");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (op == OP_APPEND) && (count_q != FULL_COUNT)
      |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("append did not grow the table");

  a_search_count_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |=> $stable(count_q))
    else $error("entry count moved during a search");

  a_result_not_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !load)
    else $error("result register overwritten while stalled");

endmodule

// ===== sv/oate_cell.sv =====
// one table cell: holds one entry, shifts with its neighbors, flags a key match
module oate_cell
  import oate_pkg::*;
(
  input  logic              clk_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [DATA_W-1:0] lower_i,
  input  logic [DATA_W-1:0] upper_i,
  output logic [DATA_W-1:0] entry_o,
  output logic              match_o
);

  logic [DATA_W-1:0] entry_q, entry_d;
  logic              match_q, match_d;
  logic [CNT_W-1:0]  idx_ext;

  assign idx_ext = {1'b0, idx_i};

  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.cmd)
      CMD_APPEND: begin
        if (idx_ext == ctrl_i.count) entry_d = value_i;
      end
      CMD_INSERT: begin
        if (idx_i == ctrl_i.pos) entry_d = value_i;
        else if (idx_i > ctrl_i.pos) entry_d = lower_i;
      end
      CMD_DELETE: begin
        if (idx_i >= ctrl_i.pos) entry_d = upper_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  // only live entries may match
  assign match_d = (entry_q == value_i) && (idx_ext < ctrl_i.count);

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (ctrl_i.search_en) match_q <= match_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

// ===== sv/oate_prio.sv =====
// lowest-index priority encoder over the registered cell match flags
module oate_prio
  import oate_pkg::*;
(
  input  logic [DEPTH-1:0] match_i,
  output logic             hit_o,
  output logic [IDX_W-1:0] pos_o
);

  logic [NGRP-1:0]   grp_hit;
  logic [GRP_W-1:0]  grp_sel [NGRP];
  logic [NGRP_W-1:0] top_sel;

  // first level: lowest flag inside each group of eight
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_hit[g] = |match_i[g*GRP +: GRP];
      grp_sel[g] = '0;
      for (int j = GRP - 1; j >= 0; j--) begin
        if (match_i[g*GRP + j]) grp_sel[g] = GRP_W'(j);
      end
    end
  end

  // second level: lowest group with a flag
  always_comb begin
    top_sel = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_hit[g]) top_sel = NGRP_W'(g);
    end
  end

  assign hit_o = |grp_hit;
  assign pos_o = {top_sel, grp_sel[top_sel]};

endmodule
